FILE: design/group_bucket_selector_wrr_assert.svh
// Assertion macros shared by the group engine.
`ifndef GROUP_BUCKET_SELECTOR_WRR_ASSERT_SVH
`define GROUP_BUCKET_SELECTOR_WRR_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define GBS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication checked outside reset.
`define GBS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

FILE: design/gbs_pkg.sv
package gbs_pkg;

   localparam int MAX_BUCKETS_DEF = 16;
   localparam int WEIGHT_BITS_DEF = 16;
   localparam int CNT_BITS        = 64;
   localparam int TYPE_BITS       = 2;
   localparam int BCOUNT_BITS     = 5;
   localparam int IDX_BITS        = 4;
   localparam int LEN_BITS        = 16;
   localparam int IN_WEIGHT_BITS  = 16;

   localparam logic [1:0] OP_LOAD    = 2'd0;
   localparam logic [1:0] OP_PACKET  = 2'd1;
   localparam logic [1:0] OP_RD_BKT  = 2'd2;
   localparam logic [1:0] OP_RD_GRP  = 2'd3;

   localparam logic [1:0] GT_ALL      = 2'd0;
   localparam logic [1:0] GT_SELECT   = 2'd1;
   localparam logic [1:0] GT_INDIRECT = 2'd2;
   localparam logic [1:0] GT_FAILOVER = 2'd3;

   localparam logic CSR_GROUP_TYPE   = 1'b0;
   localparam logic CSR_BUCKET_COUNT = 1'b1;

endpackage

FILE: design/group_bucket_selector_wrr.sv
// Loads: bucket 0 sets gcd and max directly; other loads also run the gcd in
//   S_GCD, one subtract or swap step at a time.
// Group read and empty group: beat in the cycle after accept; bucket read: S_RDA, S_RDB.
// Packet: S_CNTGP, S_CNTGB, S_CNTP, S_CNTB, S_OUT per counted bucket (all type:
//   every bucket); select adds S_WRAP per wrap of a stale index, and S_SEL, S_SELCHK per scanned bucket.
// Sequential: ready only in idle. Reset: synchronous active high; bucket
//   counters cleared by a pass over all MAX_BUCKETS buckets after reset; weights undefined.
`include "group_bucket_selector_wrr_assert.svh"
module group_bucket_selector_wrr #(
   parameter int MAX_BUCKETS = gbs_pkg::MAX_BUCKETS_DEF,
   parameter int WEIGHT_BITS = gbs_pkg::WEIGHT_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_opcode,
   input  logic [gbs_pkg::IDX_BITS-1:0]  req_bucket_index,
   input  logic [15:0]                   req_weight_value,
   input  logic [15:0]                   req_packet_length,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [gbs_pkg::IDX_BITS-1:0]  rsp_chosen_bucket,
   output logic                          rsp_found,
   output logic                          rsp_last,
   output logic [63:0]                   rsp_packets_seen,
   output logic [63:0]                   rsp_bytes_seen,
   input  logic                          csr_write,
   input  logic                          csr_index,
   input  logic [4:0]                    csr_data
);
   import gbs_pkg::*;

   localparam int BI = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
   localparam int NB = $clog2(MAX_BUCKETS + 1);
   localparam int WB = WEIGHT_BITS;

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_GCD    = 4'd2;
   localparam logic [3:0] S_RDA    = 4'd3;
   localparam logic [3:0] S_RDB    = 4'd4;
   localparam logic [3:0] S_CNTP   = 4'd5;
   localparam logic [3:0] S_CNTB   = 4'd6;
   localparam logic [3:0] S_OUT    = 4'd7;
   localparam logic [3:0] S_SEL    = 4'd8;
   localparam logic [3:0] S_SELCHK = 4'd9;
   localparam logic [3:0] S_CNTGP  = 4'd10;
   localparam logic [3:0] S_CNTGB  = 4'd11;
   localparam logic [3:0] S_WRAP   = 4'd12;

   logic [3:0] state_ff, state_in;
   logic [1:0] gtype_ff;
   logic [4:0] bcount_ff;

   logic [WB-1:0] wmem [MAX_BUCKETS];
   logic [63:0]   pmem [MAX_BUCKETS];
   logic [63:0]   bmem [MAX_BUCKETS];
   logic [WB-1:0] wrd_ff;
   logic [63:0]   prd_ff, brd_ff;

   logic [WB-1:0] gcd_ff, gcd_in, max_ff, max_in, cur_ff, cur_in;
   logic [WB-1:0] ga_ff, ga_in, gb_ff, gb_in;
   logic [BI-1:0] prev_ff, prev_in;
   logic          pvalid_ff, pvalid_in;
   logic [63:0]   gp_ff, gp_in, gby_ff, gby_in;

   logic [1:0]    op_ff, op_in;
   logic [BI-1:0] b_ff, b_in;
   logic [3:0]    ridx_ff, ridx_in;
   logic [LEN_BITS-1:0] len_ff, len_in;
   logic [NB-1:0] n_ff, n_in, step_ff, step_in;

   logic          rv_ff, rv_in;
   logic [3:0]    rb_ff, rb_in;
   logic          rf_ff, rf_in, rl_ff, rl_in;
   logic [63:0]   rp_ff, rp_in, rby_ff, rby_in;

   // shared 64-bit adder
   logic [63:0] add_a, add_b, add_s;
   assign add_s = add_a + add_b;

   logic          pwe, bwe, wwe;
   logic [63:0]   pwd, bwd;
   logic [WB-1:0] wwd;
   logic [BI-1:0] waddr, raddr;

   logic [NB-1:0] n_req;
   assign n_req = (32'(bcount_ff) > MAX_BUCKETS) ? NB'(MAX_BUCKETS) : NB'(bcount_ff);

   logic [BI-1:0] nxt_b;
   assign nxt_b = pvalid_ff ? ((NB'(prev_ff) + NB'(1) >= n_ff) ? '0 : BI'(prev_ff + 1'b1))
                            : '0;

   always_ff @(posedge clock) begin
      if (wwe) wmem[waddr] <= wwd;
      if (pwe) pmem[waddr] <= pwd;
      if (bwe) bmem[waddr] <= bwd;
      wrd_ff <= wmem[raddr];
      prd_ff <= pmem[raddr];
      brd_ff <= bmem[raddr];
   end

   always_comb begin
      state_in = state_ff;
      gcd_in = gcd_ff; max_in = max_ff; cur_in = cur_ff;
      ga_in = ga_ff; gb_in = gb_ff;
      prev_in = prev_ff; pvalid_in = pvalid_ff;
      gp_in = gp_ff; gby_in = gby_ff;
      op_in = op_ff; b_in = b_ff; ridx_in = ridx_ff; len_in = len_ff;
      n_in = n_ff; step_in = step_ff;
      rv_in = rv_ff; rb_in = rb_ff; rf_in = rf_ff; rl_in = rl_ff;
      rp_in = rp_ff; rby_in = rby_ff;
      add_a = '0; add_b = '0;
      pwe = 1'b0; bwe = 1'b0; wwe = 1'b0;
      pwd = '0; bwd = '0; wwd = '0;
      waddr = b_ff; raddr = b_ff;
      req_ready = 1'b0;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            pwe = 1'b1; bwe = 1'b1;
            if (NB'(b_ff) + NB'(1) >= NB'(MAX_BUCKETS)) begin
               state_in = S_IDLE;
               b_in = '0;
            end else begin
               b_in = BI'(b_ff + 1'b1);
            end
         end
         S_IDLE: begin
            req_ready = !rv_ff || rsp_ready;
            if (req_valid && req_ready) begin
               op_in = req_opcode;
               ridx_in = req_bucket_index;
               len_in = req_packet_length;
               n_in = n_req;
               step_in = '0;
               b_in = BI'(req_bucket_index);
               case (req_opcode)
                  OP_LOAD: begin
                     if (32'(req_bucket_index) < MAX_BUCKETS) begin
                        wwe = 1'b1;
                        waddr = BI'(req_bucket_index);
                        wwd = WB'(req_weight_value);
                        if (req_bucket_index == '0) begin
                           gcd_in = WB'(req_weight_value);
                           max_in = WB'(req_weight_value);
                           cur_in = '0; prev_in = '0; pvalid_in = 1'b0;
                        end else begin
                           if (WB'(req_weight_value) > max_ff)
                              max_in = WB'(req_weight_value);
                           ga_in = gcd_ff;
                           gb_in = WB'(req_weight_value);
                           state_in = S_GCD;
                        end
                     end
                  end
                  OP_RD_BKT: begin
                     raddr = BI'(req_bucket_index);
                     state_in = S_RDA;
                  end
                  OP_RD_GRP: begin
                     rv_in = 1'b1; rb_in = '0; rf_in = (n_req != '0); rl_in = 1'b1;
                     rp_in = gp_ff; rby_in = gby_ff;
                  end
                  default: begin
                     if (n_req == '0) begin
                        rv_in = 1'b1; rb_in = '0; rf_in = 1'b0; rl_in = 1'b1;
                        rp_in = '0; rby_in = '0;
                     end else if (gtype_ff == GT_SELECT) begin
                        state_in = S_WRAP;
                     end else begin
                        b_in = '0; raddr = '0;
                        state_in = S_CNTGP;
                     end
                  end
               endcase
            end
         end
         S_GCD: begin
            // gcd(a, b) by repeated subtraction of a from b, swapping a and b when b < a
            if (ga_ff == '0) begin
               gcd_in = gb_ff;
               state_in = S_IDLE;
            end else if (gb_ff >= ga_ff) begin
               gb_in = gb_ff - ga_ff;
            end else begin
               ga_in = gb_ff; gb_in = ga_ff;
            end
         end
         S_RDA: state_in = S_RDB;
         S_RDB: begin
            if (!rv_ff) begin
               rv_in = 1'b1; rb_in = ridx_ff; rl_in = 1'b1;
               if (32'(ridx_ff) < 32'(n_ff)) begin
                  rf_in = 1'b1; rp_in = prd_ff; rby_in = brd_ff;
               end else begin
                  rf_in = 1'b0; rp_in = '0; rby_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         S_WRAP: begin
            // bring a stale previous bucket below the bucket count
            if (pvalid_ff && NB'(prev_ff) >= n_ff) begin
               prev_in = prev_ff - BI'(n_ff);
            end else begin
               state_in = S_SEL;
            end
         end
         S_SEL: begin
            prev_in = nxt_b; pvalid_in = 1'b1;
            b_in = nxt_b; raddr = nxt_b;
            if (nxt_b == '0) begin
               if (cur_ff <= gcd_ff) cur_in = max_ff;
               else cur_in = cur_ff - gcd_ff;
            end
            step_in = step_ff + 1'b1;
            state_in = S_SELCHK;
         end
         S_SELCHK: begin
            if (wrd_ff >= cur_ff) begin
               state_in = S_CNTGP;
            end else if (step_ff >= n_ff) begin
               if (!rv_ff) begin
                  rv_in = 1'b1; rb_in = '0; rf_in = 1'b0; rl_in = 1'b1;
                  rp_in = '0; rby_in = '0;
                  state_in = S_IDLE;
               end
            end else begin
               state_in = S_SEL;
            end
         end
         S_CNTGP: begin
            add_a = gp_ff; add_b = 64'd1; gp_in = add_s;
            state_in = S_CNTGB;
         end
         S_CNTGB: begin
            add_a = gby_ff; add_b = 64'(len_ff); gby_in = add_s;
            state_in = S_CNTP;
         end
         S_CNTP: begin
            // wait here while the previous beat still holds the result registers
            if (!rv_ff) begin
               add_a = prd_ff; add_b = 64'd1; rp_in = add_s;
               pwe = 1'b1; pwd = add_s;
               state_in = S_CNTB;
            end
         end
         S_CNTB: begin
            add_a = brd_ff; add_b = 64'(len_ff); rby_in = add_s;
            bwe = 1'b1; bwd = add_s;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rv_ff) begin
               rv_in = 1'b1; rb_in = 4'(b_ff); rf_in = 1'b1;
               if (op_ff == OP_PACKET && gtype_ff == GT_ALL &&
                   NB'(b_ff) + NB'(1) < n_ff) begin
                  rl_in = 1'b0;
                  b_in = BI'(b_ff + 1'b1); raddr = BI'(b_ff + 1'b1);
                  state_in = S_CNTGP;
               end else begin
                  rl_in = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         gtype_ff <= '0; bcount_ff <= '0;
         gcd_ff <= '0; max_ff <= '0; cur_ff <= '0;
         prev_ff <= '0; pvalid_ff <= 1'b0;
         gp_ff <= '0; gby_ff <= '0;
         rv_ff <= 1'b0; b_ff <= '0;
      end else begin
         state_ff <= state_in;
         gcd_ff <= gcd_in; max_ff <= max_in; cur_ff <= cur_in;
         prev_ff <= prev_in; pvalid_ff <= pvalid_in;
         gp_ff <= gp_in; gby_ff <= gby_in;
         rv_ff <= rv_in; b_ff <= b_in;
         if (csr_write) begin
            if (csr_index == CSR_GROUP_TYPE) gtype_ff <= csr_data[1:0];
            else bcount_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      ga_ff <= ga_in; gb_ff <= gb_in;
      op_ff <= op_in; ridx_ff <= ridx_in; len_ff <= len_in;
      n_ff <= n_in; step_ff <= step_in;
      rb_ff <= rb_in; rf_ff <= rf_in; rl_ff <= rl_in;
      rp_ff <= rp_in; rby_ff <= rby_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_chosen_bucket = rb_ff;
   assign rsp_found = rf_ff;
   assign rsp_last = rl_ff;
   assign rsp_packets_seen = rp_ff;
   assign rsp_bytes_seen = rby_ff;

   `GBS_ASSERT_IMP(a_ready_idle, clock, reset, req_ready, state_ff == S_IDLE)
   `GBS_ASSERT_IMP(a_notfound_zero, clock, reset, rsp_valid && !rsp_found && rsp_chosen_bucket == '0, rsp_packets_seen == '0 || rsp_packets_seen == gp_ff)
   `GBS_ASSERT_NXT(a_clear_done, clock, reset, state_ff == S_IDLE && !req_valid, state_ff == S_IDLE)
   `GBS_ASSERT_IMP(a_sel_step, clock, reset, state_ff == S_SELCHK, step_ff <= n_ff)

endmodule
